### hdl/wbps_pkg.sv
// shared types and constants for the wildcard byte pattern scanner
`timescale 1ns / 1ps
`default_nettype none
package wbps_pkg;

   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_PTR_BITS   = 3;
   localparam int CSR_ADDR_BITS  = 6;
   localparam int CSR_DATA_BITS  = 64;

   typedef enum logic [1:0] {
      KIND_MATCH  = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_FAILED = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      REG_PATTERN_LENGTH = 3'd0,
      REG_PATTERN_WORD_0 = 3'd1,
      REG_PATTERN_WORD_1 = 3'd2,
      REG_PATTERN_WORD_2 = 3'd3,
      REG_PATTERN_WORD_3 = 3'd4,
      REG_WILDCARD_MASK  = 3'd5,
      REG_MATCH_LIMIT    = 3'd6,
      REG_BASE_ADDRESS   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [5:0]   pattern_length;
      logic [255:0] pattern_bytes;
      logic [31:0]  wildcard_mask;
      logic [31:0]  match_limit;
      logic [63:0]  base_address;
   } cfg_type;

   typedef struct packed {
      logic match;
      logic last;
      logic failed;
   } scan_flags_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] match_offset;
      logic [63:0] match_address;
      logic [31:0] total_matches;
      logic        final_item;
   } rsp_item_type;

endpackage
`default_nettype wire

### hdl/wbps_req_if.sv
// input byte channel interface
`timescale 1ns / 1ps
`default_nettype none
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       range_end;

   modport source (output valid, output data_byte, output range_end, input ready);
   modport sink (input valid, input data_byte, input range_end, output ready);
endinterface
`default_nettype wire

### hdl/wbps_rsp_if.sv
// result channel interface
`timescale 1ns / 1ps
`default_nettype none
interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] match_offset;
   logic [63:0] match_address;
   logic [31:0] total_matches;
   logic        final_item;

   modport source (output valid, output kind, output match_offset, output match_address,
                   output total_matches, output final_item, input ready);
   modport sink (input valid, input kind, input match_offset, input match_address,
                 input total_matches, input final_item, output ready);
endinterface
`default_nettype wire

### hdl/wbps_match.sv
// byte window shift register, parallel wildcard compare and byte counter
`timescale 1ns / 1ps
`default_nettype none
module wbps_match #(
   parameter int MAX_PATTERN_BYTES = 32,
   parameter int OFFSET_BITS       = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [7:0]                  data_byte,
   input  wire logic                        range_end,
   input  wire wbps_pkg::cfg_type           cfg,
   output logic                             s1_valid,
   output wbps_pkg::scan_flags_type         s1_flags,
   output logic [OFFSET_BITS-1:0]           s1_offset
);

   localparam int IDX_BITS  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
   localparam int WIN_DEPTH = 2 ** IDX_BITS;

   logic [7:0]             win_ff [WIN_DEPTH];
   logic [7:0]             win_in [WIN_DEPTH];
   logic [OFFSET_BITS-1:0] seen_ff;
   logic [OFFSET_BITS-1:0] seen_in;
   logic                   s1_valid_ff;
   wbps_pkg::scan_flags_type s1_flags_ff;
   logic [OFFSET_BITS-1:0] s1_offset_ff;

   logic [MAX_PATTERN_BYTES-1:0] byte_ok;
   logic [OFFSET_BITS-1:0] len_ext;
   logic                   len_ok;
   logic                   raw_match;
   logic                   failed;

   always_comb begin
      win_in[0] = data_byte;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         win_in[k] = win_ff[k-1];
      end
   end

   assign seen_in = (seen_ff == {OFFSET_BITS{1'b1}}) ? seen_ff
                                                     : seen_ff + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
   assign len_ext = OFFSET_BITS'(cfg.pattern_length);
   assign len_ok  = (cfg.pattern_length != 6'd0) &&
                    (cfg.pattern_length <= 6'(MAX_PATTERN_BYTES));

   // pattern byte i lines up with the byte that arrived length-1-i transfers ago
   always_comb begin
      logic [5:0] idx;
      idx = 6'd0;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         idx = cfg.pattern_length - 6'(i) - 6'd1;
         byte_ok[i] = (6'(i) >= cfg.pattern_length) || cfg.wildcard_mask[i] ||
                      (win_in[idx[IDX_BITS-1:0]] == cfg.pattern_bytes[8*i +: 8]);
      end
   end

   assign raw_match = len_ok && (seen_in >= len_ext) && (&byte_ok);
   assign failed    = !len_ok || (len_ext > seen_in);

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < WIN_DEPTH; k++) begin
            win_ff[k] <= win_in[k];
         end
         s1_flags_ff.match  <= raw_match;
         s1_flags_ff.last   <= range_end;
         s1_flags_ff.failed <= failed;
         s1_offset_ff       <= seen_in - len_ext;
      end
      if (reset) begin
         seen_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            seen_ff <= range_end ? '0 : seen_in;
         end
      end
   end

   assign s1_valid  = s1_valid_ff;
   assign s1_flags  = s1_flags_ff;
   assign s1_offset = s1_offset_ff;

endmodule
`default_nettype wire

### hdl/wbps_tally.sv
// match limit, saturating match count and result item assembly
`timescale 1ns / 1ps
`default_nettype none
module wbps_tally #(
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     s1_valid,
   input  wire wbps_pkg::scan_flags_type s1_flags,
   input  wire logic [OFFSET_BITS-1:0]   s1_offset,
   input  wire wbps_pkg::cfg_type        cfg,
   output wbps_pkg::rsp_item_type        item0,
   output wbps_pkg::rsp_item_type        item1,
   output logic [1:0]                    push_count
);

   logic [31:0] total_ff;
   logic [31:0] total_in;
   logic        limit_ff;
   logic        limit_in;
   logic        report;
   logic        last;
   logic [63:0] off64;
   wbps_pkg::rsp_item_type match_item;
   wbps_pkg::rsp_item_type end_item;

   assign report   = s1_valid && s1_flags.match && !limit_ff;
   assign last     = s1_valid && s1_flags.last;
   assign total_in = (report && (total_ff != 32'hFFFF_FFFF)) ? total_ff + 32'd1 : total_ff;
   assign limit_in = limit_ff ||
                     (report && (cfg.match_limit != 32'd0) && (total_in >= cfg.match_limit));
   assign off64    = 64'(s1_offset);

   always_comb begin
      match_item.kind          = wbps_pkg::KIND_MATCH;
      match_item.match_offset  = off64[31:0];
      match_item.match_address = cfg.base_address + off64;
      match_item.total_matches = total_in;
      match_item.final_item    = 1'b0;

      end_item.kind          = s1_flags.failed ? wbps_pkg::KIND_FAILED : wbps_pkg::KIND_DONE;
      end_item.match_offset  = 32'd0;
      end_item.match_address = 64'd0;
      end_item.total_matches = s1_flags.failed ? 32'd0 : total_in;
      end_item.final_item    = 1'b1;
   end

   assign item0      = report ? match_item : end_item;
   assign item1      = end_item;
   assign push_count = {1'b0, report} + {1'b0, last};

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         limit_ff <= 1'b0;
      end else if (s1_valid) begin
         if (s1_flags.last) begin
            total_ff <= '0;
            limit_ff <= 1'b0;
         end else begin
            total_ff <= total_in;
            limit_ff <= limit_in;
         end
      end
   end

endmodule
`default_nettype wire

### hdl/wbps_rsp_fifo.sv
// result queue, up to two writes and one read per cycle
`timescale 1ns / 1ps
`default_nettype none
module wbps_rsp_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire wbps_pkg::rsp_item_type item0,
   input  wire wbps_pkg::rsp_item_type item1,
   input  wire logic [1:0]             push_count,
   output logic [wbps_pkg::RSP_PTR_BITS:0] count,
   wbps_rsp_if.source                  rsp_chan
);

   localparam int PB = wbps_pkg::RSP_PTR_BITS;

   wbps_pkg::rsp_item_type mem_ff [wbps_pkg::RSP_FIFO_DEPTH];
   logic [PB-1:0] wr_ff;
   logic [PB-1:0] rd_ff;
   logic [PB:0]   count_ff;
   logic [PB-1:0] wr_next_slot;
   logic          pop;
   wbps_pkg::rsp_item_type head;

   assign wr_next_slot = wr_ff + {{(PB-1){1'b0}}, 1'b1};
   assign pop          = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ff] <= item0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next_slot] <= item1;
      end
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + PB'(push_count);
         rd_ff    <= rd_ff + {{(PB-1){1'b0}}, pop};
         count_ff <= count_ff + (PB+1)'(push_count) - {{PB{1'b0}}, pop};
      end
   end

   assign head                   = mem_ff[rd_ff];
   assign count                  = count_ff;
   assign rsp_chan.valid         = (count_ff != '0);
   assign rsp_chan.kind          = head.kind;
   assign rsp_chan.match_offset  = head.match_offset;
   assign rsp_chan.match_address = head.match_address;
   assign rsp_chan.total_matches = head.total_matches;
   assign rsp_chan.final_item    = head.final_item;

endmodule
`default_nettype wire

### hdl/wildcard_byte_pattern_scanner_core.sv
// top level: csr registers, compare stage, tally stage and result queue
// a byte's first result passes the compare stage register and then the result queue
// throughput: one byte per cycle while the result queue has room; the window
// compare for all pattern bytes runs in parallel, and a byte that gives both a
// match and a done result puts two items into the result queue
// reset: synchronous, clears csr registers, counters, match limit state and the queue
`timescale 1ns / 1ps
`default_nettype none
module wildcard_byte_pattern_scanner_core #(
   parameter int MAX_PATTERN_BYTES = 32,
   parameter int OFFSET_BITS       = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   wbps_req_if.sink                                 req_chan,
   wbps_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [wbps_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [wbps_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [wbps_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                     csr_pready
);

   wbps_pkg::cfg_type        cfg_ff;
   wbps_pkg::reg_index_type  reg_idx;
   logic                     csr_write;
   logic                     accept;
   logic                     s1_valid;
   wbps_pkg::scan_flags_type s1_flags;
   logic [OFFSET_BITS-1:0]   s1_offset;
   wbps_pkg::rsp_item_type   item0;
   wbps_pkg::rsp_item_type   item1;
   logic [1:0]               push_count;
   logic [wbps_pkg::RSP_PTR_BITS:0] fifo_count;
   logic [wbps_pkg::RSP_PTR_BITS+1:0] committed;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = wbps_pkg::reg_index_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_idx)
            wbps_pkg::REG_PATTERN_LENGTH: cfg_ff.pattern_length <= csr_pwdata[5:0];
            wbps_pkg::REG_PATTERN_WORD_0: cfg_ff.pattern_bytes[63:0] <= csr_pwdata;
            wbps_pkg::REG_PATTERN_WORD_1: cfg_ff.pattern_bytes[127:64] <= csr_pwdata;
            wbps_pkg::REG_PATTERN_WORD_2: cfg_ff.pattern_bytes[191:128] <= csr_pwdata;
            wbps_pkg::REG_PATTERN_WORD_3: cfg_ff.pattern_bytes[255:192] <= csr_pwdata;
            wbps_pkg::REG_WILDCARD_MASK:  cfg_ff.wildcard_mask <= csr_pwdata[31:0];
            wbps_pkg::REG_MATCH_LIMIT:    cfg_ff.match_limit <= csr_pwdata[31:0];
            wbps_pkg::REG_BASE_ADDRESS:   cfg_ff.base_address <= csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         wbps_pkg::REG_PATTERN_LENGTH: csr_prdata = 64'(cfg_ff.pattern_length);
         wbps_pkg::REG_PATTERN_WORD_0: csr_prdata = cfg_ff.pattern_bytes[63:0];
         wbps_pkg::REG_PATTERN_WORD_1: csr_prdata = cfg_ff.pattern_bytes[127:64];
         wbps_pkg::REG_PATTERN_WORD_2: csr_prdata = cfg_ff.pattern_bytes[191:128];
         wbps_pkg::REG_PATTERN_WORD_3: csr_prdata = cfg_ff.pattern_bytes[255:192];
         wbps_pkg::REG_WILDCARD_MASK:  csr_prdata = 64'(cfg_ff.wildcard_mask);
         wbps_pkg::REG_MATCH_LIMIT:    csr_prdata = 64'(cfg_ff.match_limit);
         wbps_pkg::REG_BASE_ADDRESS:   csr_prdata = cfg_ff.base_address;
      endcase
   end

   // room for the byte in the tally stage plus the one taken now
   assign committed      = (wbps_pkg::RSP_PTR_BITS+2)'(fifo_count) +
                           (s1_valid ? (wbps_pkg::RSP_PTR_BITS+2)'(2) : '0);
   assign req_chan.ready = (committed <= (wbps_pkg::RSP_PTR_BITS+2)'(wbps_pkg::RSP_FIFO_DEPTH - 2));
   assign accept         = req_chan.valid && req_chan.ready;

   wbps_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .OFFSET_BITS       (OFFSET_BITS)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .range_end (req_chan.range_end),
      .cfg       (cfg_ff),
      .s1_valid  (s1_valid),
      .s1_flags  (s1_flags),
      .s1_offset (s1_offset)
   );

   wbps_tally #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_tally (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_flags   (s1_flags),
      .s1_offset  (s1_offset),
      .cfg        (cfg_ff),
      .item0      (item0),
      .item1      (item1),
      .push_count (push_count)
   );

   wbps_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .item0      (item0),
      .item1      (item1),
      .push_count (push_count),
      .count      (fifo_count),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire
